### rtl/tts_pkg.sv
// Shared types and constants for the tick-driven task scheduler.
package tts_pkg;

    localparam int NUM_TASKS = 16;
    localparam int IDX_BITS  = $clog2(NUM_TASKS);
    localparam int CNT_BITS  = 16;
    localparam int PRI_BITS  = 8;
    localparam int KEY_BITS  = (CNT_BITS > PRI_BITS) ? CNT_BITS : PRI_BITS;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic MODE_SJF  = 1'b0;
    localparam logic MODE_PRIO = 1'b1;

    typedef struct packed {
        logic                ready;
        logic [PRI_BITS-1:0] prio;
        logic [CNT_BITS-1:0] cnt;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{ready: 1'b1, prio: '0, cnt: '0};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_RD_CUR,
        ST_CHECK,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_FINISH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;      // capture the request word
        logic wr_entry;  // write the requested table entry
        logic rd_cur;    // read the current task's entry
        logic check;     // decrement / keep decision on the current task
        logic scan_rd;   // read the next scan entry
        logic finish;    // commit the scan winner
    } cmd_t;

    typedef struct packed {
        logic go_scan;
        logic scan_last;
    } stat_t;

endpackage

### rtl/tts_ctrl.sv
// Controller state machine for the task scheduler.
module tts_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         req_type,
    input  tts_pkg::stat_t stat,
    output tts_pkg::cmd_t  cmd,
    output logic         busy,
    output logic         done
);
    import tts_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (req_type == REQ_WRITE) ? ST_WRITE : ST_RD_CUR;
                end
            end
            ST_WRITE:     state_next = ST_RD_CUR;
            ST_RD_CUR:    state_next = ST_CHECK;
            ST_CHECK:     state_next = stat.go_scan ? ST_SCAN : ST_DONE;
            ST_SCAN:      state_next = stat.scan_last ? ST_SCAN_LAST : ST_SCAN;
            ST_SCAN_LAST: state_next = ST_FINISH;
            ST_FINISH:    state_next = ST_DONE;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_WRITE:     cmd.wr_entry = 1'b1;
            ST_RD_CUR:    cmd.rd_cur   = 1'b1;
            ST_CHECK:     cmd.check    = 1'b1;
            ST_SCAN:      cmd.scan_rd  = 1'b1;
            ST_SCAN_LAST: cmd          = '0;
            ST_FINISH:    cmd.finish   = 1'b1;
            ST_DONE:      done         = 1'b1;
            default:      cmd          = '0;
        endcase
    end

endmodule

### rtl/tts_dpath.sv
// Datapath for the task scheduler: task table, scan compare and result word.
module tts_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tts_pkg::cmd_t                 cmd,
    output tts_pkg::stat_t                stat,
    input  logic                          cfg_valid,
    input  logic                          cfg_data,
    input  logic                          req_type,
    input  logic [tts_pkg::IDX_BITS-1:0]  task_index,
    input  logic [tts_pkg::CNT_BITS-1:0]  new_counter,
    input  logic [tts_pkg::PRI_BITS-1:0]  new_priority,
    input  logic                          new_runnable,
    output logic [tts_pkg::IDX_BITS-1:0]  running_task,
    output logic                          switched,
    output logic                          refill_needed,
    output logic [tts_pkg::CNT_BITS-1:0]  running_counter
);
    import tts_pkg::*;

    // task table; an entry never written reads as its reset value
    entry_t              mem [NUM_TASKS];
    logic [NUM_TASKS-1:0] valid_reg;

    logic                mode_reg;
    logic                req_write_reg;
    logic [IDX_BITS-1:0] req_idx_reg;
    entry_t              req_entry_reg;
    logic [IDX_BITS-1:0] cur_reg;

    logic [IDX_BITS-1:0] rd_addr;
    entry_t              rd_word_reg;
    logic                rd_valid_reg;
    logic [IDX_BITS-1:0] rd_addr_reg;
    entry_t              eff;

    logic                wr_en;
    logic [IDX_BITS-1:0] wr_addr;
    entry_t              wr_data;

    logic [IDX_BITS-1:0] scan_idx_reg;
    logic                cmp_reg;
    logic                found_reg;
    logic [IDX_BITS-1:0] best_idx_reg;
    logic [KEY_BITS-1:0] best_key_reg;
    logic [CNT_BITS-1:0] best_cnt_reg;

    logic                dec;
    logic [CNT_BITS-1:0] cnt_after;
    logic                keep;
    logic                qual;
    logic                better;
    logic [KEY_BITS-1:0] key;

    logic [IDX_BITS-1:0] res_task_reg;
    logic                res_sw_reg;
    logic                res_refill_reg;
    logic [CNT_BITS-1:0] res_cnt_reg;

    assign rd_addr = cmd.scan_rd ? scan_idx_reg : cur_reg;
    assign eff     = rd_valid_reg ? rd_word_reg : ENTRY_RESET;

    // current-task check
    assign dec       = (cur_reg != '0) && (eff.cnt != '0) && !req_write_reg;
    assign cnt_after = eff.cnt - CNT_BITS'(dec);
    assign keep      = (cur_reg != '0) && (cnt_after != '0);

    assign stat.go_scan   = !req_write_reg && !keep;
    assign stat.scan_last = (scan_idx_reg == IDX_BITS'(NUM_TASKS - 1));

    // scan compare
    assign qual = eff.ready && (eff.cnt != '0);
    always_comb
    begin
        if (mode_reg == MODE_SJF)
        begin
            key    = KEY_BITS'(eff.cnt);
            better = qual && (!found_reg || (key < best_key_reg));
        end
        else
        begin
            key    = KEY_BITS'(eff.prio);
            better = qual && (key > best_key_reg);
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = req_idx_reg;
        wr_data = req_entry_reg;
        if (cmd.wr_entry)
        begin
            wr_en = (req_idx_reg != '0);
        end
        else if (cmd.check && dec)
        begin
            wr_en       = 1'b1;
            wr_addr     = cur_reg;
            wr_data     = eff;
            wr_data.cnt = cnt_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_idx_reg         <= task_index;
            req_entry_reg.ready <= new_runnable;
            req_entry_reg.prio  <= new_priority;
            req_entry_reg.cnt   <= new_counter;
        end
        rd_addr_reg <= rd_addr;
        if (cmd.check)
        begin
            best_key_reg <= '0;
            best_cnt_reg <= '0;
            best_idx_reg <= '0;
        end
        else if (cmp_reg && better)
        begin
            best_key_reg <= key;
            best_cnt_reg <= eff.cnt;
            best_idx_reg <= rd_addr_reg;
        end
        if (cmd.check && !stat.go_scan)
        begin
            res_task_reg   <= cur_reg;
            res_sw_reg     <= 1'b0;
            res_refill_reg <= 1'b0;
            res_cnt_reg    <= req_write_reg ? eff.cnt : cnt_after;
        end
        else if (cmd.finish)
        begin
            res_task_reg   <= found_reg ? best_idx_reg : '0;
            res_sw_reg     <= (found_reg ? best_idx_reg : '0) != cur_reg;
            res_refill_reg <= !found_reg;
            res_cnt_reg    <= found_reg ? best_cnt_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            mode_reg      <= MODE_SJF;
            req_write_reg <= REQ_TICK;
            cur_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            scan_idx_reg  <= '0;
            cmp_reg       <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                req_write_reg <= req_type;
            end
            rd_valid_reg <= valid_reg[rd_addr];
            cmp_reg      <= cmd.scan_rd;
            if (cmd.check)
            begin
                scan_idx_reg <= IDX_BITS'(1);
                found_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    scan_idx_reg <= scan_idx_reg + IDX_BITS'(1);
                end
                if (cmp_reg && better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                cur_reg <= found_reg ? best_idx_reg : '0;
            end
        end
    end

    assign running_task    = res_task_reg;
    assign switched        = res_sw_reg;
    assign refill_needed   = res_refill_reg;
    assign running_counter = res_cnt_reg;

endmodule

### rtl/timer_tick_task_scheduler.sv
// Top level of the tick-driven task scheduler: controller plus datapath.
// Flow: a tick reads and checks the current entry before done; a table write first
//   stores its entry; a tick that scans reads 15 entries, one table read each.
// Throughput: one word at a time; the next start is taken the cycle after done,
//   with the scan paced by the single read port of the task table.
// Reset: asynchronous, active low; table reads as counters 0, priorities 0, all
//   runnable, idle task current, shortest-job mode. Results cannot be stalled.
module timer_tick_task_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [tts_pkg::IDX_BITS-1:0]  task_index,
    input  logic [tts_pkg::CNT_BITS-1:0]  new_counter,
    input  logic [tts_pkg::PRI_BITS-1:0]  new_priority,
    input  logic                          new_runnable,
    // result word, valid for the single cycle that done is high
    output logic                          done,
    output logic [tts_pkg::IDX_BITS-1:0]  running_task,
    output logic                          switched,
    output logic                          refill_needed,
    output logic [tts_pkg::CNT_BITS-1:0]  running_counter,
    // scheduling mode register: 0 shortest job, 1 highest priority
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);
    import tts_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // the mode register takes a word on any cycle
    assign cfg_ready = 1'b1;

    tts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    // table, current task, scan compare and result word live here
    tts_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_valid       (cfg_valid & cfg_ready),
        .cfg_data        (cfg_data),
        .req_type        (req_type),
        .task_index      (task_index),
        .new_counter     (new_counter),
        .new_priority    (new_priority),
        .new_runnable    (new_runnable),
        .running_task    (running_task),
        .switched        (switched),
        .refill_needed   (refill_needed),
        .running_counter (running_counter)
    );

endmodule

### dv/tts_sched_sb_pkg.sv
// Scoreboard for the task scheduler: table predictor and store of expected result words.
`timescale 1ns / 1ps

package tts_sched_sb_pkg;

    import tts_pkg::*;

    typedef struct packed {
        logic                req;
        logic [IDX_BITS-1:0] idx;
        logic [CNT_BITS-1:0] cnt;
        logic [PRI_BITS-1:0] prio;
        logic                rdy;
    } sched_word_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] run_task;
        logic                sw;
        logic                refill;
        logic [CNT_BITS-1:0] run_cnt;
    } sched_result_t;

    class sched_scoreboard;

        logic [CNT_BITS-1:0] slice_cnt [NUM_TASKS];
        logic [PRI_BITS-1:0] task_pri  [NUM_TASKS];
        logic                runnable  [NUM_TASKS];
        logic [IDX_BITS-1:0] cur;
        logic                mode;
        sched_result_t       expected_q [$];
        int                  errors;
        bit                  last_refill;

        function new();
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                slice_cnt[i] = '0;
                task_pri[i]  = '0;
                runnable[i]  = 1'b1;
            end
            cur         = '0;
            mode        = MODE_SJF;
            errors      = 0;
            last_refill = 1'b0;
        endfunction

        function void set_mode(logic m);
            mode = m;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Scan entries 1 upwards; strict compares keep the lowest index on a tie.
        function logic [IDX_BITS-1:0] pick_task();
            logic [IDX_BITS-1:0] best;
            logic [KEY_BITS-1:0] key;
            bit                  found;
            best  = '0;
            key   = '0;
            found = 1'b0;
            for (int i = 1; i < NUM_TASKS; i++)
            begin
                if (runnable[i] && slice_cnt[i] != '0)
                begin
                    if (mode == MODE_SJF)
                    begin
                        if (!found || KEY_BITS'(slice_cnt[i]) < key)
                        begin
                            key   = KEY_BITS'(slice_cnt[i]);
                            best  = IDX_BITS'(i);
                            found = 1'b1;
                        end
                    end
                    else if (KEY_BITS'(task_pri[i]) > key)
                    begin
                        key   = KEY_BITS'(task_pri[i]);
                        best  = IDX_BITS'(i);
                        found = 1'b1;
                    end
                end
            end
            return found ? best : '0;
        endfunction

        function void note_word(sched_word_t w);
            sched_result_t       r;
            logic [IDX_BITS-1:0] nxt;
            r.sw     = 1'b0;
            r.refill = 1'b0;
            if (w.req == REQ_WRITE)
            begin
                // entry 0 is the idle task and stays untouched
                if (w.idx != '0)
                begin
                    slice_cnt[w.idx] = w.cnt;
                    task_pri[w.idx]  = w.prio;
                    runnable[w.idx]  = w.rdy;
                end
            end
            else
            begin
                if (cur != '0 && slice_cnt[cur] != '0)
                    slice_cnt[cur] = slice_cnt[cur] - 1'b1;
                if (cur == '0 || slice_cnt[cur] == '0)
                begin
                    nxt = pick_task();
                    if (nxt == '0)
                        r.refill = 1'b1;
                    if (nxt != cur)
                        r.sw = 1'b1;
                    cur = nxt;
                end
            end
            r.run_task  = cur;
            r.run_cnt   = slice_cnt[cur];
            last_refill = r.refill;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [IDX_BITS-1:0] t, logic sw, logic rf,
                                   logic [CNT_BITS-1:0] c);
            sched_result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result word with nothing outstanding: task %0d counter %0d",
                         $time, t, c);
                return;
            end
            e = expected_q.pop_front();
            if (t !== e.run_task)
            begin
                errors++;
                $display("%0t: running_task expected %0d actual %0d", $time, e.run_task, t);
            end
            if (sw !== e.sw)
            begin
                errors++;
                $display("%0t: switched expected %0b actual %0b", $time, e.sw, sw);
            end
            if (rf !== e.refill)
            begin
                errors++;
                $display("%0t: refill_needed expected %0b actual %0b", $time, e.refill, rf);
            end
            if (c !== e.run_cnt)
            begin
                errors++;
                $display("%0t: running_counter expected %0d actual %0d", $time, e.run_cnt, c);
            end
        endfunction

    endclass

endpackage

### dv/tb_timer_tick_task_scheduler.sv
// Self-checking testbench for the tick-driven task scheduler.
`timescale 1ns / 1ps

module tb_timer_tick_task_scheduler;

    import tts_pkg::*;
    import tts_sched_sb_pkg::*;

    // slowest legal run stays well inside this limit; keep a wide margin
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int          PHASE_WORDS = 250;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                req_type;
    logic [IDX_BITS-1:0] task_index;
    logic [CNT_BITS-1:0] new_counter;
    logic [PRI_BITS-1:0] new_priority;
    logic                new_runnable;
    logic                done;
    logic [IDX_BITS-1:0] running_task;
    logic                switched;
    logic                refill_needed;
    logic [CNT_BITS-1:0] running_counter;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_data;

    sched_scoreboard     sb;
    int unsigned         cycles = 0;
    int                  quiet_left = 0;

    timer_tick_task_scheduler i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .task_index      (task_index),
        .new_counter     (new_counter),
        .new_priority    (new_priority),
        .new_runnable    (new_runnable),
        .done            (done),
        .running_task    (running_task),
        .switched        (switched),
        .refill_needed   (refill_needed),
        .running_counter (running_counter),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hang guard: a missing result word or a stuck handshake ends up here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timer_tick_task_scheduler verification failed");
            $finish;
        end
    end

    // Result words cannot be held off, so every strobe is checked on the spot.
    // Sampling at the edge sees the values of the cycle that the edge ends.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(running_task, switched, refill_needed, running_counter);
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // Mostly back-to-back or short pauses, now and then a long one, and
    // occasional stretches of forty-one words with no pause at all.
    function int next_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0)
        begin
            quiet_left = 40;
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(21, 60);
    endfunction

    // Small counters keep the scheduler switching; the odd full-range or
    // saturated value exercises the upper bits and long-running tasks.
    function automatic logic [CNT_BITS-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 70)
            return CNT_BITS'($urandom_range(1, 6));
        if (r < 85)
            return CNT_BITS'($urandom_range(7, 40));
        if (r < 95)
            return CNT_BITS'($urandom_range(0, 65535));
        return '1;
    endfunction

    // Plenty of zero and low priorities so that ties and non-qualifying
    // entries turn up often in priority mode.
    function automatic logic [PRI_BITS-1:0] pick_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return '0;
        if (r < 70)
            return PRI_BITS'($urandom_range(1, 4));
        if (r < 90)
            return PRI_BITS'($urandom_range(0, 255));
        return '1;
    endfunction

    function automatic sched_word_t mk_word(logic req, int idx, int cnt, int prio, logic rdy);
        sched_word_t w;
        w.req  = req;
        w.idx  = IDX_BITS'(idx);
        w.cnt  = CNT_BITS'(cnt);
        w.prio = PRI_BITS'(prio);
        w.rdy  = rdy;
        return w;
    endfunction

    // Ticks carry random rubbish in the entry fields, which must be ignored.
    function automatic sched_word_t rand_tick();
        return mk_word(REQ_TICK, $urandom_range(0, 15), $urandom_range(0, 65535),
                       $urandom_range(0, 255), 1'($urandom_range(0, 1)));
    endfunction

    // A refill write targets a real task, mostly with a short nonzero counter; a
    // plain write may hit entry 0 or load a zero counter.
    function automatic sched_word_t rand_write(bit refill);
        sched_word_t w;
        w.req = REQ_WRITE;
        if (refill)
        begin
            w.idx = IDX_BITS'($urandom_range(1, 15));
            w.cnt = ($urandom_range(0, 9) == 0) ? pick_count()
                                                : CNT_BITS'($urandom_range(1, 12));
            w.rdy = ($urandom_range(0, 9) != 0);
        end
        else
        begin
            w.idx = ($urandom_range(0, 19) == 0) ? '0 : IDX_BITS'($urandom_range(1, 15));
            w.cnt = pick_count();
            w.rdy = ($urandom_range(0, 4) != 0);
        end
        w.prio = pick_prio();
        return w;
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // Lower start only when a pause is wanted, so a held start is never
    // dropped and raised in the same step.
    task automatic idle_gap(int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Present a command word and hold it until the edge that takes it.
    task automatic send_word(sched_word_t w);
        start        <= 1'b1;
        req_type     <= w.req;
        task_index   <= w.idx;
        new_counter  <= w.cnt;
        new_priority <= w.prio;
        new_runnable <= w.rdy;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_word(w);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Mode changes only with the block idle and every result word in.
    task automatic write_mode(logic m);
        drain();
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.set_mode(m);
        cfg_valid <= 1'b0;
    endtask

    task automatic put(sched_word_t w);
        idle_gap(next_gap());
        send_word(w);
    endtask

    // Mostly ticks with writes mixed in; after a refill request the host
    // normally reloads a handful of entries, but sometimes just keeps ticking.
    task automatic run_phase(int n_words);
        int k;
        int burst;
        k = 0;
        while (k < n_words)
        begin
            if (sb.last_refill && $urandom_range(0, 9) != 0)
            begin
                burst = $urandom_range(2, 7);
                repeat (burst)
                begin
                    put(rand_write(1'b1));
                    k++;
                end
            end
            else
            begin
                if ($urandom_range(0, 99) < 30)
                    put(rand_write(1'b0));
                else
                    put(rand_tick());
                k++;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------

    initial
    begin
        sb            = new();
        rst_n        <= 1'b0;
        start        <= 1'b0;
        req_type     <= REQ_TICK;
        task_index   <= '0;
        new_counter  <= '0;
        new_priority <= '0;
        new_runnable <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_data     <= MODE_SJF;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Shortest-job mode straight out of reset.
        put(rand_tick());                                   // empty table: refill
        put(mk_word(REQ_WRITE, 0, 16'hFFFF, 8'hFF, 1'b1));  // idle entry, ignored
        put(rand_tick());                                   // still nothing to run
        put(mk_word(REQ_WRITE, 15, 16'hFFFF, 8'hFF, 1'b1));
        put(mk_word(REQ_WRITE, 1, 1, 0, 1'b1));
        put(mk_word(REQ_WRITE, 2, 3, 8'h80, 1'b0));         // not runnable
        put(mk_word(REQ_WRITE, 3, 1, 0, 1'b1));             // ties with entry 1
        put(rand_tick());                                   // lowest index wins
        put(rand_tick());
        put(rand_tick());                                   // only the long job left
        put(mk_word(REQ_WRITE, 15, 2, 8'hFF, 1'b0));        // current made unrunnable
        put(rand_tick());                                   // keeps running
        put(rand_tick());                                   // runs out: refill

        // Priority mode: zero priority and zero counter both disqualify.
        write_mode(MODE_PRIO);
        put(mk_word(REQ_WRITE, 4, 5, 0, 1'b1));
        put(mk_word(REQ_WRITE, 5, 2, 7, 1'b1));
        put(mk_word(REQ_WRITE, 6, 9, 7, 1'b1));
        put(mk_word(REQ_WRITE, 7, 0, 8'hFF, 1'b1));
        put(rand_tick());
        put(rand_tick());
        put(rand_tick());
        put(mk_word(REQ_WRITE, 6, 0, 7, 1'b1));             // zero the current task
        put(rand_tick());                                   // reselect from zero count

        // Random phases across both modes, extremes included.
        write_mode(MODE_SJF);
        run_phase(PHASE_WORDS);
        write_mode(MODE_PRIO);
        run_phase(PHASE_WORDS);
        write_mode(MODE_SJF);
        run_phase(PHASE_WORDS);
        write_mode(1'($urandom_range(0, 1)));
        run_phase(PHASE_WORDS);
        write_mode(MODE_PRIO);
        run_phase(PHASE_WORDS);
        write_mode(1'($urandom_range(0, 1)));
        run_phase(PHASE_WORDS);
        write_mode(MODE_SJF);
        run_phase(PHASE_WORDS);

        // Let the last word land, then watch for stray strobes a while.
        drain();
        repeat (25) @(posedge clk);
        if (sb.errors == 0)
            $display("timer_tick_task_scheduler verification clean");
        else
            $display("timer_tick_task_scheduler verification failed");
        $finish;
    end

endmodule
